// ----- src/msf_pkg.sv -----
package msf_pkg;
   localparam int VIDX_W = 6;
   localparam int WGT_W = 16;
   localparam int SUM_W = 24;
   localparam int KEY_W = WGT_W + 2 * VIDX_W;
   localparam int VCNT_W = 7;

   typedef struct packed {
      logic load;
      logic clear;
      logic sort_start;
      logic scan_start;
   } msf_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic sort_done;
      logic scan_done;
   } msf_status_type;
endpackage

// ----- src/msf_req_if.sv -----
interface msf_req_if;
   logic valid;
   logic ready;
   logic [msf_pkg::VIDX_W-1:0] u_index;
   logic [msf_pkg::VIDX_W-1:0] v_index;
   logic signed [msf_pkg::WGT_W-1:0] weight;
   logic last_edge;
   modport source (output valid, u_index, v_index, weight, last_edge, input ready);
   modport sink (input valid, u_index, v_index, weight, last_edge, output ready);
endinterface

interface msf_rsp_if;
   logic valid;
   logic ready;
   logic [msf_pkg::VIDX_W-1:0] edge_u;
   logic [msf_pkg::VIDX_W-1:0] edge_v;
   logic signed [msf_pkg::WGT_W-1:0] edge_weight;
   logic edge_valid;
   logic last_result;
   logic signed [msf_pkg::SUM_W-1:0] tree_weight;
   logic signed [msf_pkg::SUM_W-1:0] saved_weight;
   modport source (output valid, edge_u, edge_v, edge_weight, edge_valid, last_result,
      tree_weight, saved_weight, input ready);
   modport sink (input valid, edge_u, edge_v, edge_weight, edge_valid, last_result,
      tree_weight, saved_weight, output ready);
endinterface

// ----- src/msf_ctrl.sv -----
module msf_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_last,
   output logic req_ready,
   output msf_pkg::msf_cmd_type cmd,
   input  msf_pkg::msf_status_type status
);
   import msf_pkg::*;

   typedef enum logic [2:0] {CLEAR, LOAD, SORT, SCAN} state_type;
   state_type state_ff;

   assign req_ready = (state_ff == LOAD);
   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == LOAD) && req_valid;
      cmd.clear = (state_ff == CLEAR);
      cmd.sort_start = cmd.load && req_last;
      cmd.scan_start = (state_ff == SORT) && status.sort_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         unique case (state_ff)
            CLEAR: if (status.clear_done) state_ff <= LOAD;
            LOAD: if (req_valid && req_last) state_ff <= SORT;
            SORT: if (status.sort_done) state_ff <= SCAN;
            SCAN: if (status.scan_done) state_ff <= CLEAR;
            default: state_ff <= CLEAR;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.clear) else $error("ready while clearing");
   a_sort: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_start |=> !req_ready) else $error("ready after last");
   a_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !req_ready) else $error("scan while loading");
`endif
endmodule

// ----- src/msf_datapath.sv -----
module msf_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic clock,
   input  logic reset,
   input  msf_pkg::msf_cmd_type cmd,
   output msf_pkg::msf_status_type status,
   input  logic [msf_pkg::VIDX_W-1:0] in_u,
   input  logic [msf_pkg::VIDX_W-1:0] in_v,
   input  logic signed [msf_pkg::WGT_W-1:0] in_w,
   input  logic [msf_pkg::VCNT_W-1:0] vcount,
   output logic out_valid,
   input  logic out_ready,
   output logic [msf_pkg::VIDX_W-1:0] out_u,
   output logic [msf_pkg::VIDX_W-1:0] out_v,
   output logic signed [msf_pkg::WGT_W-1:0] out_w,
   output logic out_edge_valid,
   output logic out_last,
   output logic signed [msf_pkg::SUM_W-1:0] out_tree,
   output logic signed [msf_pkg::SUM_W-1:0] out_saved
);
   import msf_pkg::*;

   localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int VA_W = $clog2(MAX_VERTICES);

   typedef enum logic [3:0] {
      P_IDLE, P_SO_I, P_SO_RD, P_SO_CMP, P_SO_WR, P_SC_RD, P_SC_CHK,
      P_FU_RD, P_FU, P_FV_RD, P_FV, P_EMIT, P_FIN, P_WAIT
   } phase_type;

   logic [KEY_W-1:0] mem [MAX_EDGES];
   logic [VA_W-1:0] par [MAX_VERTICES];
   logic [EC_W-1:0] total_ff;
   logic signed [SUM_W-1:0] all_ff, tree_ff;
   phase_type ph_ff;
   logic [EC_W-1:0] i_ff, j_ff;
   logic [KEY_W-1:0] key_ff, rd_ff, prev_ff;
   logic have_prev_ff;
   logic [VA_W:0] clr_ff;
   logic [VA_W-1:0] x_ff, ru_ff;
   logic [VA_W:0] steps_ff;
   logic [5:0] cnt_ff;
   logic [VCNT_W-1:0] n_ff;
   logic [VA_W-1:0] p_ff;
   logic [VIDX_W-1:0] hu_ff, hv_ff;
   logic signed [WGT_W-1:0] hw_ff;
   logic [VIDX_W-1:0] ku, kv;

   assign ku = key_ff[2*VIDX_W-1:VIDX_W];
   assign kv = key_ff[VIDX_W-1:0];
   assign status.clear_done = (clr_ff == VA_W'(0) + (VA_W+1)'(MAX_VERTICES - 1));
   assign status.sort_done = (ph_ff == P_SO_I) && (i_ff >= total_ff);
   assign status.scan_done = (ph_ff == P_WAIT) && out_valid && out_ready && out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         all_ff <= '0;
         tree_ff <= '0;
         ph_ff <= P_IDLE;
         clr_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         if (cmd.clear) begin
            par[clr_ff[VA_W-1:0]] <= clr_ff[VA_W-1:0];
            clr_ff <= status.clear_done ? '0 : clr_ff + 1'b1;
            total_ff <= '0;
            all_ff <= '0;
            tree_ff <= '0;
            ph_ff <= P_IDLE;
         end
         if (cmd.load && total_ff < EC_W'(MAX_EDGES)) begin
            mem[total_ff[EA_W-1:0]] <= {in_w ^ {1'b1, {(WGT_W-1){1'b0}}}, in_u, in_v};
            total_ff <= total_ff + 1'b1;
            all_ff <= all_ff + SUM_W'(in_w);
         end
         if (cmd.sort_start) begin
            ph_ff <= P_SO_I;
            i_ff <= EC_W'(1);
            n_ff <= (vcount == '0) ? VCNT_W'(1) :
               (vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount;
         end
         if (out_valid && out_ready) out_valid <= 1'b0;
         case (ph_ff)
            P_SO_I: begin
               if (i_ff < total_ff) begin
                  key_ff <= mem[i_ff[EA_W-1:0]];
                  j_ff <= i_ff;
                  ph_ff <= P_SO_RD;
               end else begin
                  ph_ff <= P_SC_RD;
                  i_ff <= '0;
                  have_prev_ff <= 1'b0;
                  cnt_ff <= '0;
               end
            end
            P_SO_RD: begin
               if (j_ff == '0) ph_ff <= P_SO_WR;
               else begin
                  rd_ff <= mem[j_ff[EA_W-1:0] - 1'b1];
                  ph_ff <= P_SO_CMP;
               end
            end
            P_SO_CMP: begin
               if (rd_ff > key_ff) begin
                  mem[j_ff[EA_W-1:0]] <= rd_ff;
                  j_ff <= j_ff - 1'b1;
                  ph_ff <= P_SO_RD;
               end else ph_ff <= P_SO_WR;
            end
            P_SO_WR: begin
               mem[j_ff[EA_W-1:0]] <= key_ff;
               i_ff <= i_ff + 1'b1;
               ph_ff <= P_SO_I;
            end
            P_SC_RD: begin
               if (i_ff < total_ff && cnt_ff != 6'd63) begin
                  key_ff <= mem[i_ff[EA_W-1:0]];
                  i_ff <= i_ff + 1'b1;
                  ph_ff <= P_SC_CHK;
               end else ph_ff <= P_FIN;
            end
            P_SC_CHK: begin
               ph_ff <= P_SC_RD;
               if (!(have_prev_ff && key_ff == prev_ff)) begin
                  have_prev_ff <= 1'b1;
                  prev_ff <= key_ff;
                  if (VCNT_W'(ku) < n_ff && VCNT_W'(kv) < n_ff) begin
                     x_ff <= ku[VA_W-1:0];
                     steps_ff <= '0;
                     ph_ff <= P_FU_RD;
                  end
               end
            end
            P_FU_RD, P_FV_RD: begin
               p_ff <= par[x_ff];
               ph_ff <= (ph_ff == P_FU_RD) ? P_FU : P_FV;
            end
            P_FU, P_FV: begin
               if (p_ff == x_ff || steps_ff == (VA_W+1)'(MAX_VERTICES)) begin
                  if (ph_ff == P_FU) begin
                     ru_ff <= x_ff;
                     x_ff <= kv[VA_W-1:0];
                     steps_ff <= '0;
                     ph_ff <= P_FV_RD;
                  end else if (x_ff == ru_ff) ph_ff <= P_SC_RD;
                  else begin
                     par[x_ff] <= ru_ff;
                     tree_ff <= tree_ff + SUM_W'($signed(key_ff[KEY_W-1:2*VIDX_W]
                        ^ {1'b1, {(WGT_W-1){1'b0}}}));
                     ph_ff <= P_EMIT;
                  end
               end else begin
                  x_ff <= p_ff;
                  steps_ff <= steps_ff + 1'b1;
                  ph_ff <= (ph_ff == P_FU) ? P_FU_RD : P_FV_RD;
               end
            end
            // the newest chosen edge is held back until it is known whether it is the last
            P_EMIT: if (cnt_ff == '0 || !out_valid) begin
               if (cnt_ff != '0) begin
                  out_u <= hu_ff;
                  out_v <= hv_ff;
                  out_w <= hw_ff;
                  out_edge_valid <= 1'b1;
                  out_last <= 1'b0;
                  out_tree <= '0;
                  out_saved <= '0;
                  out_valid <= 1'b1;
               end
               hu_ff <= ku;
               hv_ff <= kv;
               hw_ff <= $signed(key_ff[KEY_W-1:2*VIDX_W] ^ {1'b1, {(WGT_W-1){1'b0}}});
               cnt_ff <= cnt_ff + 1'b1;
               ph_ff <= P_SC_RD;
            end
            P_FIN: if (!out_valid) begin
               if (cnt_ff == '0) begin
                  out_u <= '0;
                  out_v <= '0;
                  out_w <= '0;
                  out_edge_valid <= 1'b0;
               end else begin
                  out_u <= hu_ff;
                  out_v <= hv_ff;
                  out_w <= hw_ff;
                  out_edge_valid <= 1'b1;
               end
               out_last <= 1'b1;
               out_tree <= tree_ff;
               out_saved <= all_ff - tree_ff;
               out_valid <= 1'b1;
               ph_ff <= P_WAIT;
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- src/minimum_spanning_forest.sv -----
// after the last edge, an insertion sort orders the stored edges, shifting each larger
// entry up one place; the scan then reads each edge, walks the parent table to both
// roots and emits each chosen edge, stalling while an earlier result is still waiting
// throughput: one edge loaded per cycle, one graph at a time
// reset: synchronous; a clearing pass over the parent table
// runs after reset and after each graph before edges are taken; vertex_count resets to 64
module minimum_spanning_forest #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic clock,
   input  logic reset,
   msf_req_if.sink req,
   msf_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [msf_pkg::VCNT_W-1:0] csr_write_data
);
   import msf_pkg::*;

   msf_cmd_type cmd;
   msf_status_type status;
   logic [VCNT_W-1:0] vcount_ff;
   logic last_hold;

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= VCNT_W'(64);
      else if (csr_write_enable) vcount_ff <= csr_write_data;
   end

   always_comb begin
      last_hold = (rsp.valid && !rsp.last_result) ? 1'b1 : 1'b0;
      // fin arm: hold off final result until previous one taken
   end

   msf_ctrl u_ctrl (.clock, .reset, .req_valid(req.valid), .req_last(req.last_edge),
      .req_ready(req.ready), .cmd, .status);

   msf_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
      .clock, .reset, .cmd, .status, .in_u(req.u_index), .in_v(req.v_index),
      .in_w(req.weight), .vcount(vcount_ff), .out_valid(rsp.valid),
      .out_ready(rsp.ready), .out_u(rsp.edge_u), .out_v(rsp.edge_v),
      .out_w(rsp.edge_weight), .out_edge_valid(rsp.edge_valid),
      .out_last(rsp.last_result), .out_tree(rsp.tree_weight),
      .out_saved(rsp.saved_weight));

`ifndef SYNTHESIS
   a_noload: assert property (@(posedge clock) disable iff (reset)
      last_hold |-> !req.ready) else $error("load during output");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_result |=> !rsp.valid)
      else $error("result after last");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.edge_valid |-> rsp.last_result) else $error("bad empty");
`endif
endmodule

// ----- bench/tb_minimum_spanning_forest.sv -----
module tb_minimum_spanning_forest;
   timeunit 1ns;
   timeprecision 1ps;
   import msf_pkg::*;

   localparam int NUM_VERTICES = 64;
   localparam int EDGE_CAPACITY = 256;
   localparam int IDLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [VIDX_W-1:0] edge_u;
      logic [VIDX_W-1:0] edge_v;
      logic [WGT_W-1:0] edge_weight;
      logic edge_valid;
      logic last_result;
      logic [SUM_W-1:0] tree_weight;
      logic [SUM_W-1:0] saved_weight;
   } tree_edge_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [VCNT_W-1:0] csr_write_data;

   msf_req_if req_if ();
   msf_rsp_if rsp_if ();

   minimum_spanning_forest #(
      .MAX_VERTICES(NUM_VERTICES),
      .MAX_EDGES(EDGE_CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // model state
   logic [KEY_W-1:0] loaded_keys[$];
   logic [SUM_W-1:0] loaded_sum;
   int unsigned model_vertex_count;
   tree_edge_type pending_edges[$];

   int errors;
   int idle_cycles;
   bit idling;
   int hold_off;
   int rsp_burst;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("mismatch on %s: got %0h expected %0h at %0t", field, got, want, $realtime);
   endtask

   function automatic int find_root(ref logic [VIDX_W-1:0] parent[NUM_VERTICES], input int x);
      int p;
      for (int steps = 0; steps < NUM_VERTICES; steps++) begin
         p = int'(parent[x]);
         if (p == x) break;
         x = p;
      end
      return x;
   endfunction

   task automatic build_forest();
      logic [KEY_W-1:0] sorted[$];
      logic [VIDX_W-1:0] parent[NUM_VERTICES];
      logic [KEY_W-1:0] prev;
      bit have_prev;
      int n;
      int ru;
      int rv;
      int count;
      logic [SUM_W-1:0] tsum;
      tree_edge_type r;
      tree_edge_type found[$];
      sorted = loaded_keys;
      sorted.sort();
      n = model_vertex_count;
      if (n < 1) n = 1;
      if (n > NUM_VERTICES) n = NUM_VERTICES;
      for (int i = 0; i < NUM_VERTICES; i++) parent[i] = VIDX_W'(i);
      have_prev = 0;
      count = 0;
      tsum = '0;
      foreach (sorted[i]) begin
         if (have_prev && sorted[i] == prev) continue;
         have_prev = 1;
         prev = sorted[i];
         r = '0;
         r.edge_v = prev[VIDX_W-1:0];
         r.edge_u = prev[2*VIDX_W-1:VIDX_W];
         r.edge_weight = prev[KEY_W-1:2*VIDX_W] ^ 16'h8000;
         r.edge_valid = 1'b1;
         if (int'(r.edge_u) >= n || int'(r.edge_v) >= n) continue;
         ru = find_root(parent, int'(r.edge_u));
         rv = find_root(parent, int'(r.edge_v));
         if (ru == rv) continue;
         if (count >= NUM_VERTICES - 1) break;
         parent[rv] = VIDX_W'(ru);
         tsum = tsum + SUM_W'(signed'(r.edge_weight));
         found = {found, r};
         count++;
      end
      if (count == 0) begin
         r = '0;
         found = {found, r};
      end
      r = found.pop_back();
      r.last_result = 1'b1;
      r.tree_weight = tsum;
      r.saved_weight = loaded_sum - tsum;
      found = {found, r};
      pending_edges = {pending_edges, found};
      loaded_keys.delete();
      loaded_sum = '0;
   endtask

   task automatic model_edge(logic [VIDX_W-1:0] u, logic [VIDX_W-1:0] v,
                             logic [WGT_W-1:0] w, logic last);
      logic [KEY_W-1:0] key;
      if (loaded_keys.size() < EDGE_CAPACITY) begin
         key = {w ^ 16'h8000, u, v};
         loaded_keys = {loaded_keys, key};
         loaded_sum = loaded_sum + SUM_W'(signed'(w));
      end
      if (last) build_forest();
   endtask

   task automatic send_edge(int u, int v, int w, bit last);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.u_index <= VIDX_W'(u);
      req_if.v_index <= VIDX_W'(v);
      req_if.weight <= WGT_W'(w);
      req_if.last_edge <= last;
      do @(posedge clock); while (!req_if.ready);
      model_edge(VIDX_W'(u), VIDX_W'(v), WGT_W'(w), last);
   endtask

   task automatic wait_results();
      req_if.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
   endtask

   task automatic set_vertex_count(int n);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= VCNT_W'(n);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_vertex_count = unsigned'(n);
   endtask

   task automatic send_random_graph(int edges, int vmax);
      int w;
      for (int i = 0; i < edges; i++) begin
         case ($urandom_range(0, 2))
            0: w = $urandom_range(0, 7) - 4;
            1: w = $urandom_range(0, 65535) - 32768;
            default: w = $urandom_range(0, 1) ? 32767 : -32768;
         endcase
         if ($urandom_range(0, 7) == 0)
            send_edge($urandom_range(0, 63), $urandom_range(0, 63), w, i == edges - 1);
         else
            send_edge($urandom_range(0, vmax), $urandom_range(0, vmax), w, i == edges - 1);
      end
   endtask

   task automatic test_extreme_edges();
      send_edge(0, 63, -32768, 0);
      send_edge(63, 0, 32767, 0);
      send_edge(5, 5, -100, 0);
      send_edge(1, 2, 7, 0);
      send_edge(1, 2, 7, 0);
      send_edge(2, 1, 7, 0);
      send_edge(0, 1, 7, 0);
      send_edge(42, 21, 0, 1);
      wait_results();
   endtask

   task automatic test_empty_forest();
      send_edge(9, 9, 1234, 1);
      set_vertex_count(1);
      send_edge(0, 1, -5, 0);
      send_edge(0, 0, 300, 1);
      wait_results();
   endtask

   task automatic test_vertex_count_limits();
      set_vertex_count(0);
      send_edge(0, 1, 10, 0);
      send_edge(1, 0, -10, 1);
      set_vertex_count(127);
      send_edge(62, 63, 1, 0);
      send_edge(0, 63, 2, 1);
      set_vertex_count(3);
      send_edge(0, 3, -1, 0);
      send_edge(2, 1, 4, 0);
      send_edge(0, 2, 4, 1);
      wait_results();
   endtask

   task automatic test_output_stall();
      set_vertex_count(16);
      hold_off = 400;
      send_random_graph(8, 15);
      send_random_graph(8, 15);
      wait_results();
   endtask

   task automatic test_random_graphs(int items);
      int sent;
      int edges;
      int vc;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 3))
            0: vc = 64;
            1: vc = $urandom_range(1, 8);
            default: vc = $urandom_range(0, 127);
         endcase
         set_vertex_count(vc);
         edges = $urandom_range(1, 12);
         send_random_graph(edges, (vc > 64) ? 63 : ((vc == 0) ? 1 : vc));
         sent += edges;
      end
      wait_results();
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_if.ready <= 1'b0;
      end else if (rsp_burst > 0) begin
         rsp_burst--;
         rsp_if.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_burst = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // compare every result transaction against the oldest prediction
   always @(posedge clock) begin
      tree_edge_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_edges.size() == 0) begin
            report_mismatch("unexpected result", rsp_if.edge_u, 0);
         end else begin
            want = pending_edges.pop_front();
            if (rsp_if.edge_u !== want.edge_u)
               report_mismatch("edge_u", rsp_if.edge_u, want.edge_u);
            if (rsp_if.edge_v !== want.edge_v)
               report_mismatch("edge_v", rsp_if.edge_v, want.edge_v);
            if (rsp_if.edge_weight !== want.edge_weight)
               report_mismatch("edge_weight", rsp_if.edge_weight, want.edge_weight);
            if (rsp_if.edge_valid !== want.edge_valid)
               report_mismatch("edge_valid", rsp_if.edge_valid, want.edge_valid);
            if (rsp_if.last_result !== want.last_result)
               report_mismatch("last_result", rsp_if.last_result, want.last_result);
            if (rsp_if.tree_weight !== want.tree_weight)
               report_mismatch("tree_weight", rsp_if.tree_weight, want.tree_weight);
            if (rsp_if.saved_weight !== want.saved_weight)
               report_mismatch("saved_weight", rsp_if.saved_weight, want.saved_weight);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      errors = 0;
      idle_cycles = 0;
      idling = 1;
      hold_off = 0;
      rsp_burst = 0;
      loaded_sum = '0;
      model_vertex_count = 64;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.u_index = '0;
      req_if.v_index = '0;
      req_if.weight = '0;
      req_if.last_edge = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_edges();
      test_empty_forest();
      test_vertex_count_limits();
      test_output_stall();
      test_random_graphs(60);
      idling = 0;
      test_random_graphs(30);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
